// ===== design/pca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pca_pkg;

  // Port and sum widths. The sums are sized for the longest set of full-width samples.
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 17;
  localparam int SUMX_W   = 33;
  localparam int SXY_W    = 48;
  localparam int SQ_W     = 47;
  localparam int RES_W    = 16;

  // Back end arithmetic widths.
  localparam int WIDE_W  = 64;
  localparam int PP_W    = 128;
  localparam int MUL_A_W = 160;
  localparam int MUL_B_W = 64;
  localparam int Q_W     = 15;
  localparam int R_SHIFT = 30;

  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_MAX_PAIRS   = 65536;
  localparam int DEF_SAMPLE_BITS = 16;

  // One finished set of running sums, as handed from the front to the back.
  typedef struct packed {
    logic        [CNT_W-1:0]  count;
    logic signed [SUMX_W-1:0] sx;
    logic signed [SUMX_W-1:0] sy;
    logic signed [SXY_W-1:0]  sxy;
    logic        [SQ_W-1:0]   sxx;
    logic        [SQ_W-1:0]   syy;
  } sums_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_A_W-1:0] prod;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ===== design/pca_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pca_front #(
  parameter int MAX_PAIRS   = pca_pkg::DEF_MAX_PAIRS,
  parameter int SAMPLE_BITS = pca_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [pca_pkg::SAMPLE_W-1:0]  sample_x_i,
  input  wire logic [pca_pkg::SAMPLE_W-1:0]  sample_y_i,
  input  wire logic                          last_pair_i,
  output pca_pkg::sums_t                     push_data_o,
  output logic                               push_o
);
  import pca_pkg::*;

  localparam int SH = SAMPLE_W - SAMPLE_BITS;

  sums_t sums_q, sums_d;
  logic [SAMPLE_W-1:0] x_sh, y_sh;
  logic signed [SAMPLE_W-1:0] xs, ys;
  logic signed [2*SAMPLE_W-1:0] pxy, pxx, pyy;

  // Keep the low SAMPLE_BITS bits and sign-extend from the top one.
  assign x_sh = sample_x_i << SH;
  assign y_sh = sample_y_i << SH;
  assign xs   = $signed(x_sh) >>> SH;
  assign ys   = $signed(y_sh) >>> SH;
  assign pxy  = xs * ys;
  assign pxx  = xs * xs;
  assign pyy  = ys * ys;

  always_comb begin
    sums_d = sums_q;
    if (accept_i && (sums_q.count < CNT_W'(MAX_PAIRS))) begin
      sums_d.count = sums_q.count + CNT_W'(1);
      sums_d.sx    = sums_q.sx + SUMX_W'(xs);
      sums_d.sy    = sums_q.sy + SUMX_W'(ys);
      sums_d.sxy   = sums_q.sxy + SXY_W'(pxy);
      sums_d.sxx   = sums_q.sxx + SQ_W'($unsigned(pxx));
      sums_d.syy   = sums_q.syy + SQ_W'($unsigned(pyy));
    end
  end

  assign push_o      = accept_i && last_pair_i;
  assign push_data_o = sums_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '0;
    end else if (push_o) begin
      sums_q <= '0;
    end else begin
      sums_q <= sums_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/pca_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pca_queue (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire pca_pkg::sums_t push_data_i,
  input  wire logic   pop_i,
  output pca_pkg::sums_t pop_data_o,
  output logic        empty_o,
  output logic        full_o
);
  import pca_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  sums_t mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_QW-1:0] count_q;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == CNT_QW'(QUEUE_DEPTH));
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_QW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_QW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/pca_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pca_mul (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire pca_pkg::mul_req_t req_i,
  output pca_pkg::mul_rsp_t rsp_o
);
  import pca_pkg::*;

  logic [MUL_A_W-1:0] a_q, acc_q;
  logic [MUL_B_W-1:0] b_q;
  logic               busy_q;
  logic               done;

  // Shift-add over the bits of b; stops as soon as no set bit is left.
  assign done       = busy_q && (b_q == '0);
  assign rsp_o.done = done;
  assign rsp_o.prod = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q && !done) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

endmodule

`default_nettype wire

// ===== design/pca_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pca_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire pca_pkg::sums_t             pop_data_i,
  input  wire logic                       empty_i,
  output logic                            pop_o,
  output pca_pkg::mul_req_t               mul_req_o,
  input  wire pca_pkg::mul_rsp_t          mul_rsp_i,
  output logic                            result_valid_o,
  output logic [pca_pkg::RES_W-1:0]       correlation_o,
  output logic                            undefined_o
);
  import pca_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_WAIT  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  typedef enum logic [3:0] {
    OP_NSXX, OP_SXSX, OP_NSYY, OP_SYSY, OP_NSXY, OP_SXSY, OP_VXVY, OP_MAGSQ, OP_TRIAL
  } op_e;

  localparam int BIT_W = $clog2(Q_W);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  sums_t  snap_q, snap_d;
  logic [WIDE_W-1:0]  tmp_q, tmp_d, vx_q, vx_d, vy_q, vy_d, num_q, num_d;
  logic [PP_W-1:0]    pp_q, pp_d;
  logic [MUL_A_W-1:0] rr_q, rr_d;
  logic [Q_W-1:0]     q_q, q_d, cand;
  logic [2*Q_W-1:0]   csq;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [RES_W-1:0]   corr_q, corr_d;
  logic               undef_q, undef_d;
  logic [WIDE_W-1:0]  n64, sx64, sy64, sxy64, low;

  assign n64   = WIDE_W'(snap_q.count);
  assign sx64  = WIDE_W'(snap_q.sx);
  assign sy64  = WIDE_W'(snap_q.sy);
  assign sxy64 = WIDE_W'(snap_q.sxy);
  assign low   = mul_rsp_i.prod[WIDE_W-1:0];
  assign cand  = q_q | (Q_W'(1) << bit_q);
  assign csq   = cand * cand;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    snap_d  = snap_q;
    tmp_d   = tmp_q;
    vx_d    = vx_q;
    vy_d    = vy_q;
    num_d   = num_q;
    pp_d    = pp_q;
    rr_d    = rr_q;
    q_d     = q_q;
    bit_d   = bit_q;
    corr_d  = corr_q;
    undef_d = undef_q;
    pop_o   = 1'b0;
    mul_req_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          snap_d  = pop_data_i;
          op_d    = OP_NSXX;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        mul_req_o.start = 1'b1;
        case (op_q)
          OP_NSXX:  begin mul_req_o.a = MUL_A_W'(n64);  mul_req_o.b = MUL_B_W'(snap_q.sxx); end
          OP_SXSX:  begin mul_req_o.a = MUL_A_W'(sx64); mul_req_o.b = sx64;  end
          OP_NSYY:  begin mul_req_o.a = MUL_A_W'(n64);  mul_req_o.b = MUL_B_W'(snap_q.syy); end
          OP_SYSY:  begin mul_req_o.a = MUL_A_W'(sy64); mul_req_o.b = sy64;  end
          OP_NSXY:  begin mul_req_o.a = MUL_A_W'(n64);  mul_req_o.b = sxy64; end
          OP_SXSY:  begin mul_req_o.a = MUL_A_W'(sx64); mul_req_o.b = sy64;  end
          OP_VXVY:  begin mul_req_o.a = MUL_A_W'(vx_q); mul_req_o.b = vy_q;  end
          OP_MAGSQ: begin mul_req_o.a = MUL_A_W'(tmp_q); mul_req_o.b = tmp_q; end
          OP_TRIAL: begin mul_req_o.a = MUL_A_W'(pp_q); mul_req_o.b = MUL_B_W'(csq); end
          default:  begin mul_req_o.a = '0; mul_req_o.b = '0; end
        endcase
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_rsp_i.done) begin
          state_d = ST_ISSUE;
          case (op_q)
            OP_NSXX:  begin tmp_d = low; op_d = OP_SXSX; end
            OP_SXSX:  begin vx_d = tmp_q - low; op_d = OP_NSYY; end
            OP_NSYY:  begin tmp_d = low; op_d = OP_SYSY; end
            OP_SYSY:  begin vy_d = tmp_q - low; op_d = OP_NSXY; end
            OP_NSXY:  begin tmp_d = low; op_d = OP_SXSY; end
            OP_SXSY:  begin num_d = tmp_q - low; state_d = ST_CHECK; end
            OP_VXVY:  begin pp_d = mul_rsp_i.prod[PP_W-1:0]; op_d = OP_MAGSQ; end
            OP_MAGSQ: begin
              rr_d  = mul_rsp_i.prod << R_SHIFT;
              q_d   = '0;
              bit_d = BIT_W'(Q_W - 1);
              op_d  = OP_TRIAL;
            end
            OP_TRIAL: begin
              if (mul_rsp_i.prod <= rr_q) begin
                q_d = cand;
              end
              if (bit_q == '0) begin
                state_d = ST_EMIT;
                corr_d  = num_q[WIDE_W-1]
                          ? RES_W'(0) - {1'b0, ((mul_rsp_i.prod <= rr_q) ? cand : q_q)}
                          : {1'b0, ((mul_rsp_i.prod <= rr_q) ? cand : q_q)};
                undef_d = 1'b0;
              end else begin
                bit_d = bit_q - BIT_W'(1);
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CHECK: begin
        if ((snap_q.count < CNT_W'(2)) || (vx_q == '0) || (vy_q == '0)) begin
          corr_d  = '0;
          undef_d = 1'b1;
          state_d = ST_EMIT;
        end else begin
          // Magnitude of the numerator; the sign is applied at the end.
          tmp_d   = num_q[WIDE_W-1] ? WIDE_W'(0) - num_q : num_q;
          op_d    = OP_VXVY;
          state_d = ST_ISSUE;
        end
      end
      ST_EMIT: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign result_valid_o = (state_q == ST_EMIT);
  assign correlation_o  = corr_q;
  assign undefined_o    = undef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_NSXX;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q  <= snap_d;
    tmp_q   <= tmp_d;
    vx_q    <= vx_d;
    vy_q    <= vy_d;
    num_q   <= num_d;
    pp_q    <= pp_d;
    rr_q    <= rr_d;
    q_q     <= q_d;
    corr_q  <= corr_d;
    undef_q <= undef_d;
  end

endmodule

`default_nettype wire

// ===== design/pearson_correlation_accumulator_unit.sv =====
// Channel   Direction  Ports                                       Transfer
// request   in         start, busy, sample_x_i, sample_y_i,         start high, busy low
//                      last_pair_i
// result    out        result_valid_o, correlation_o, undefined_o   one cycle per strobe
//
// Each sample pair is folded into the running sums in the cycle it is taken, so requests
// can arrive every cycle while busy is low. A pair flagged as last pushes its finished sums
// into a queue of two sets; busy is high only while that queue is full.
// The back end works on one set at a time through a shared shift-add multiplier: six
// products with b operands of up to 64 bits, two more of up to 64 bits, then fifteen
// trial products with b operands of up to 30 bits.
// Reset clears the sums, the queue and the sequencer; the receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module pearson_correlation_accumulator_unit #(
  parameter int MAX_PAIRS   = pca_pkg::DEF_MAX_PAIRS,
  parameter int SAMPLE_BITS = pca_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pca_pkg::SAMPLE_W-1:0]  sample_x_i,
  input  wire logic [pca_pkg::SAMPLE_W-1:0]  sample_y_i,
  input  wire logic                          last_pair_i,
  output logic                               result_valid_o,
  output logic [pca_pkg::RES_W-1:0]          correlation_o,
  output logic                               undefined_o
);
  import pca_pkg::*;

  sums_t    push_data, pop_data;
  logic     accept, push, pop, empty, full;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // A request is taken whenever the queue has room for a finished set.
  assign busy   = full;
  assign accept = start && !busy;

  pca_front #(
    .MAX_PAIRS  (MAX_PAIRS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .sample_x_i (sample_x_i),
    .sample_y_i (sample_y_i),
    .last_pair_i(last_pair_i),
    .push_data_o(push_data),
    .push_o     (push)
  );

  pca_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty),
    .full_o     (full)
  );

  // The back end computes the two variances and the covariance numerator, then finds
  // the Q1.15 magnitude one bit at a time by comparing squared trial values.
  pca_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_data_i    (pop_data),
    .empty_i       (empty),
    .pop_o         (pop),
    .mul_req_o     (mul_req),
    .mul_rsp_i     (mul_rsp),
    .result_valid_o(result_valid_o),
    .correlation_o (correlation_o),
    .undefined_o   (undefined_o)
  );

  pca_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  // An undefined coefficient is always reported as zero.
  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && undefined_o |-> correlation_o == '0)
    else $error("undefined result with nonzero coefficient");

  // The 15-bit magnitude keeps the coefficient off the most negative code.
  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> correlation_o != {1'b1, {(RES_W-1){1'b0}}})
    else $error("coefficient outside the saturated range");

  // Each set yields a single strobe, never two in a row.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // The queue is never reported full and empty at once, and never popped while empty.
  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(empty && full) && !(pop && empty))
    else $error("queue state inconsistent");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pca_pkg::*;

  // Worst case is every pair closing a set.
  localparam int LIMIT_CYCLES = 10_000_000;
  localparam int DRAIN_CYCLES = 3000;
  localparam int N_PAIRS      = 2000;

  typedef struct {
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
    logic                last;
  } pair_req_t;

  typedef struct {
    logic [RES_W-1:0] corr;
    logic             undef;
  } coeff_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start_r = 1'b0;
  logic [SAMPLE_W-1:0] x_r = '0;
  logic [SAMPLE_W-1:0] y_r = '0;
  logic last_r = 1'b0;
  logic busy;
  logic res_valid;
  logic [RES_W-1:0] corr;
  logic undef;

  pair_req_t pending[$];
  coeff_t    coeffs_due[$];
  int errors = 0;
  int cycles = 0;
  int pairs_taken = 0;
  int coeffs_seen = 0;
  int undef_seen = 0;
  int gap = 0;
  bit taken = 0;

  // Model of the running sums.
  int unsigned m_cnt = 0;
  longint m_sx = 0, m_sy = 0, m_sxy = 0, m_sxx = 0, m_syy = 0;

  pearson_correlation_accumulator_unit dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start_r), .busy(busy),
    .sample_x_i(x_r), .sample_y_i(y_r), .last_pair_i(last_r),
    .result_valid_o(res_valid), .correlation_o(corr), .undefined_o(undef)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Largest q in [0, 32767] with q^2 * vx * vy <= 2^30 * mag^2, by binary search.
  function automatic int unsigned q15_of(logic [63:0] mag, logic [63:0] vx, logic [63:0] vy);
    logic [191:0] rhs, prod, lhs;
    int unsigned lo, hi, mid;
    rhs = ({128'd0, mag} * {128'd0, mag}) << 30;
    prod = {128'd0, vx} * {128'd0, vy};
    lo = 0;
    hi = 32767;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      lhs = prod * mid * mid;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Folds one accepted pair into the sums; a last pair queues the coefficient.
  task automatic fold_pair(pair_req_t p);
    longint xs, ys;
    logic signed [127:0] n, vx, vy, num;
    coeff_t c;
    int unsigned q;
    if (m_cnt < DEF_MAX_PAIRS) begin
      xs = longint'($signed(p.x));
      ys = longint'($signed(p.y));
      m_cnt++;
      m_sx += xs;
      m_sy += ys;
      m_sxy += xs * ys;
      m_sxx += xs * xs;
      m_syy += ys * ys;
    end
    if (!p.last) return;
    n = m_cnt;
    vx = n * m_sxx - 128'(m_sx) * m_sx;
    vy = n * m_syy - 128'(m_sy) * m_sy;
    num = n * m_sxy - 128'(m_sx) * m_sy;
    if (m_cnt < 2 || vx == 0 || vy == 0) begin
      c.corr = '0;
      c.undef = 1'b1;
    end else begin
      q = q15_of(num < 0 ? 64'(-num) : 64'(num), 64'(vx), 64'(vy));
      c.corr = num < 0 ? RES_W'(-q) : RES_W'(q);
      c.undef = 1'b0;
    end
    coeffs_due.push_back(c);
    m_cnt = 0;
    m_sx = 0; m_sy = 0; m_sxy = 0; m_sxx = 0; m_syy = 0;
  endtask

  // Requests are taken and results checked at the rising edge.
  always @(posedge clk) begin
    coeff_t e;
    taken <= rst_n && start_r && !busy;
    if (rst_n && start_r && !busy) begin
      fold_pair(pending.pop_front());
      pairs_taken++;
    end
    if (rst_n && res_valid) begin
      coeffs_seen++;
      if (coeffs_due.size() == 0) begin
        $error("unexpected result: correlation %0d undefined %0b", $signed(corr), undef);
        errors++;
      end else begin
        e = coeffs_due.pop_front();
        if (e.undef) undef_seen++;
        if (corr !== e.corr) begin
          $error("correlation: expected %0d, got %0d", $signed(e.corr), $signed(corr));
          errors++;
        end
        if (undef !== e.undef) begin
          $error("undefined: expected %0b, got %0b", e.undef, undef);
          errors++;
        end
      end
    end
  end

  // The driver holds a request until it is taken, and otherwise may pause in bursts.
  // Near the end of the stimulus it stops pausing.
  always @(negedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b0;
    end else if (start_r && !taken) begin
      start_r <= 1'b1;
    end else if (gap > 0) begin
      gap <= gap - 1;
      start_r <= 1'b0;
    end else if (pending.size() > 300 && $urandom_range(0, 9) == 0) begin
      gap <= $urandom_range(0, 15);
      start_r <= 1'b0;
    end else if (pending.size() > 0) begin
      x_r <= pending[0].x;
      y_r <= pending[0].y;
      last_r <= pending[0].last;
      start_r <= 1'b1;
    end else begin
      start_r <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", coeffs_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_pair(int x, int y, bit last);
    pair_req_t p;
    p.x = SAMPLE_W'(x);
    p.y = SAMPLE_W'(y);
    p.last = last;
    pending.push_back(p);
  endtask

  // A set of the given length and a random flavor: free, correlated, anticorrelated, constant,
  // pinned to the extremes, or small and perfectly correlated.
  task automatic add_random_set(int len);
    int mode, x, y, k;
    mode = $urandom_range(0, 5);
    k = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < len; i++) begin
      x = $urandom_range(0, 65535) - 32768;
      y = $urandom_range(0, 65535) - 32768;
      case (mode)
        1: y = x / 2 + $urandom_range(0, 200) - 100;
        2: y = -x / 2 + $urandom_range(0, 2000) - 1000;
        3: x = k;
        4: begin
          x = $urandom_range(0, 1) ? 32767 : -32768;
          y = $urandom_range(0, 1) ? 32767 : -32768;
        end
        5: begin
          x = $urandom_range(0, 15) - 8;
          y = x * 3;
        end
        default: ;
      endcase
      add_pair(x, y, i == len - 1);
    end
  endtask

  initial begin
    // Directed sets: lone pair, constant, extreme, perfectly (anti)correlated, mixed.
    add_pair(100, 200, 1);
    add_pair(-32768, 5, 0); add_pair(-32768, 9, 1);
    add_pair(3, 7, 0); add_pair(4, 7, 0); add_pair(5, 7, 1);
    add_pair(-32768, -32768, 0); add_pair(32767, 32767, 1);
    add_pair(-32768, 32767, 0); add_pair(32767, -32768, 1);
    add_pair(1, 2, 0); add_pair(2, 4, 0); add_pair(3, 6, 1);
    add_pair(1, -2, 0); add_pair(2, -4, 0); add_pair(3, -6, 1);
    add_pair(1, 5, 0); add_pair(2, 1, 0); add_pair(3, 4, 0); add_pair(0, -1, 1);

    while (pending.size() < N_PAIRS)
      add_random_set($urandom_range(0, 9) == 0 ? $urandom_range(9, 64) : $urandom_range(1, 8));

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (pending.size() != 0 || coeffs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d sample pairs taken, %0d coefficients checked (%0d undefined).",
             pairs_taken, coeffs_seen, undef_seen);
    if (errors == 0 && coeffs_due.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
